[src/itoa_pkg.sv]
package itoa_pkg;

  // output format codes carried on the operation field
  typedef enum logic [1:0] {
    OP_UDEC = 2'd0,
    OP_SDEC = 2'd1,
    OP_OCT  = 2'd2,
    OP_HEX  = 2'd3
  } op_e;

  // one digit slot, wide enough for a hex digit
  typedef logic [3:0] digit_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // lower-case digit characters "0123456789abcdef"
  function automatic logic [7:0] digit_char(input digit_t d);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h61;
      4'd11:   c = 8'h62;
      4'd12:   c = 8'h63;
      4'd13:   c = 8'h64;
      4'd14:   c = 8'h65;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

endpackage

[src/itoa_bcd.sv]
module itoa_bcd import itoa_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int NDEC        = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [VALUE_WIDTH-1:0]       value_i,
  output logic                         done_o,
  output digit_t [NDEC-1:0]            bcd_o
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  digit_t [NDEC-1:0]      bcd_q, bcd_d;
  digit_t [NDEC-1:0]      adj;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;

  // shift-add-3: correct every digit, then shift one binary bit in
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = CW'(VALUE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d[0] = {adj[0][2:0], bin_q[VALUE_WIDTH-1]};
      for (int i = 1; i < NDEC; i++) begin
        bcd_d[i] = {adj[i][2:0], adj[i-1][3]};
      end
      bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

[src/integer_to_ascii_radix_unit.sv]
// channel | handshake                | payload
// --------+--------------------------+-------------------------------
// in      | in_valid_i / in_ready_o  | value_i, operation_i
// out     | out_valid_o / out_ready_i| char_code_o, last_o (one char per beat)
//
// decimal formats run a shift-add-3 converter, one binary bit per cycle;
// octal and hex load their digits directly. leading zero digits are then
// dropped one per cycle, keeping at least one, and each remaining digit goes
// to the output register in turn, waiting while the out channel is stalled
// prefix characters ('-', '0', "0x") go out ahead of the digits as soon as
// the output register is free, also while the converter is busy
// rst_ni clears the sequencer and output valid; a stalled out channel simply
// holds the current beat and digit output waits, in_ready_o is low until done
module integer_to_ascii_radix_unit import itoa_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [1:0]             operation_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             char_code_o,
  output logic                   last_o
);

  // digit counts per base
  localparam int NDEC  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NOCT  = (VALUE_WIDTH + 2) / 3;
  localparam int NSLOT = (NOCT > NDEC) ? NOCT : NDEC;
  localparam int PADW  = NSLOT * 4;
  localparam int SW    = $clog2(NSLOT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_e;

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [1:0]             pre_q, pre_d;       // prefix chars still to send
  logic [SW-1:0]          cnt_q, cnt_d;       // digit slots left
  digit_t [NSLOT-1:0]     dig_q, dig_d;       // digit slots, msd at the top
  logic                   ovalid_q, ovalid_d;
  logic [7:0]             ochar_q, ochar_d;
  logic                   olast_q, olast_d;

  op_e                    op_in;
  logic                   accept;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [PADW-1:0]        pad;
  logic                   out_free;
  logic                   conv_start;
  logic                   conv_done;
  digit_t [NDEC-1:0]      bcd;
  logic [7:0]             pre_char;

  assign op_in      = op_e'(operation_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign neg        = (op_in == OP_SDEC) && value_i[VALUE_WIDTH-1];
  assign mag        = neg ? (~value_i + VALUE_WIDTH'(1)) : value_i;
  assign pad        = PADW'(mag);
  assign out_free   = !ovalid_q || out_ready_i;
  assign conv_start = accept && (op_in == OP_UDEC || op_in == OP_SDEC);

  itoa_bcd #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDEC        (NDEC)
  ) u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (mag),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  // which prefix character is next
  always_comb begin
    case (op_q)
      OP_HEX:  pre_char = (pre_q == 2'd2) ? CH_ZERO : CH_X;
      OP_OCT:  pre_char = CH_ZERO;
      OP_SDEC: pre_char = CH_MINUS;
      default: pre_char = CH_ZERO;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    pre_d    = pre_q;
    cnt_d    = cnt_q;
    dig_d    = dig_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;

    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end

    // prefix beats go out as soon as the output register is free
    if (state_q != S_IDLE && pre_q != 2'd0 && out_free) begin
      ovalid_d = 1'b1;
      ochar_d  = pre_char;
      olast_d  = 1'b0;
      pre_d    = pre_q - 2'd1;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = op_in;
          cnt_d = SW'(NSLOT);
          case (op_in)
            OP_OCT: begin
              pre_d = 2'd1;
              for (int i = 0; i < NSLOT; i++) begin
                dig_d[i] = {1'b0, pad[3*i +: 3]};
              end
              state_d = S_SKIP;
            end
            OP_HEX: begin
              pre_d = 2'd2;
              for (int i = 0; i < NSLOT; i++) begin
                dig_d[i] = pad[4*i +: 4];
              end
              state_d = S_SKIP;
            end
            OP_SDEC: begin
              pre_d   = neg ? 2'd1 : 2'd0;
              state_d = S_CONV;
            end
            default: begin
              pre_d   = 2'd0;
              state_d = S_CONV;
            end
          endcase
        end
      end
      S_CONV: begin
        if (conv_done) begin
          dig_d = '0;
          for (int i = 0; i < NDEC; i++) begin
            dig_d[i] = bcd[i];
          end
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (dig_q[NSLOT-1] == 4'd0 && cnt_q != SW'(1)) begin
          for (int i = NSLOT - 1; i > 0; i--) begin
            dig_d[i] = dig_q[i-1];
          end
          dig_d[0] = 4'd0;
          cnt_d    = cnt_q - SW'(1);
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (pre_q == 2'd0 && out_free) begin
          ovalid_d = 1'b1;
          ochar_d  = digit_char(dig_q[NSLOT-1]);
          olast_d  = (cnt_q == SW'(1));
          for (int i = NSLOT - 1; i > 0; i--) begin
            dig_d[i] = dig_q[i-1];
          end
          dig_d[0] = 4'd0;
          cnt_d    = cnt_q - SW'(1);
          if (cnt_q == SW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pre_q    <= 2'd0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      ochar_q  <= '0;
      olast_q  <= 1'b0;
      op_q     <= OP_UDEC;
    end else begin
      state_q  <= state_d;
      pre_q    <= pre_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      ochar_q  <= ochar_d;
      olast_q  <= olast_d;
      op_q     <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  assign out_valid_o = ovalid_q;
  assign char_code_o = ochar_q;
  assign last_o      = olast_q;

endmodule
